// ===== rtl/core/awsrch_pkg.sv =====
// Shared types and constants for the sliding-window anagram search core.
// Used by the core top level and by the histogram read-modify-write unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package awsrch_pkg;

  // Symbol and histogram bin geometry
  localparam int SYM_W    = 7;
  localparam int NUM_SYMS = 128;
  localparam int BIN_W    = 10;

  // Result queue sizing
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // Item commands carried on in_tuser
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_t;

  // Operation applied to one histogram bin
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_INC   = 2'd1,
    OP_DEC   = 2'd2,
    OP_CLEAR = 2'd3
  } bin_op_t;

  // Per-item info that rides along with the bin operations
  typedef struct packed {
    logic is_clear;
    logic is_text;
    logic fill_eq;   // window is full once this text item is in
    logic ovf;       // pattern symbol dropped
  } item_tag_t;

  // One histogram slot: one bin operation per cycle
  typedef struct packed {
    logic      vld;
    bin_op_t   op;
    logic      last;  // final slot of its item
    item_tag_t tag;
  } slot_t;

  // Item completion from the histogram unit
  typedef struct packed {
    logic      vld;
    item_tag_t tag;
    logic      nz_zero;  // no nonzero bins after this item
  } done_t;

  // Result item, lowest bit first: window_match, found, pattern_overflow
  typedef struct packed {
    logic ovf;
    logic found;
    logic match;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/awsrch_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first when both ports hit the same address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module awsrch_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/awsrch_hist.sv =====
// Difference histogram: bin RAM with registered read, read-modify-write stage,
// write forwarding, per-bin valid bits and nonzero bin count.
// Depends on awsrch_pkg and awsrch_ram.
`timescale 1ns / 1ps
`default_nettype none

module awsrch_hist
  import awsrch_pkg::*;
#(
  parameter int ALPHABET = 128,
  parameter int IDX_W    = $clog2(ALPHABET)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire slot_t            slot_a,   // slot issuing its bin read
  input  wire logic [IDX_W-1:0] idx_a,
  output      done_t            done      // item completion, same cycle as write
);

  localparam int NZ_W = $clog2(ALPHABET + 1);

  slot_t              slot_b_r;
  logic [IDX_W-1:0]   idx_b_r;
  logic [ALPHABET-1:0] valid_r, valid_nxt;
  logic               fwd_vld_r, fwd_vld_nxt;
  logic [IDX_W-1:0]   fwd_idx_r;
  logic [BIN_W-1:0]   fwd_data_r;
  logic [NZ_W-1:0]    nz_r, nz_nxt;

  logic [BIN_W-1:0]   rd_data;
  logic [BIN_W-1:0]   cur_bin;
  logic [BIN_W-1:0]   new_bin;
  logic               rd_en;
  logic               wr_en;

  assign rd_en = slot_a.vld && ((slot_a.op == OP_INC) || (slot_a.op == OP_DEC));
  assign wr_en = slot_b_r.vld && ((slot_b_r.op == OP_INC) || (slot_b_r.op == OP_DEC));

  awsrch_ram #(
    .WIDTH (BIN_W),
    .DEPTH (ALPHABET),
    .ADDR_W(IDX_W)
  ) u_bin_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx_b_r),
    .wr_data(new_bin),
    .rd_en  (rd_en),
    .rd_addr(idx_a),
    .rd_data(rd_data)
  );

  // Current bin value: last write forwarded, unwritten bins read as zero
  always_comb begin
    if (fwd_vld_r && (fwd_idx_r == idx_b_r)) begin
      cur_bin = fwd_data_r;
    end else if (valid_r[idx_b_r]) begin
      cur_bin = rd_data;
    end else begin
      cur_bin = '0;
    end
    if (slot_b_r.op == OP_INC) begin
      new_bin = cur_bin + BIN_W'(1);
    end else begin
      new_bin = cur_bin - BIN_W'(1);
    end
  end

  // Nonzero count, valid bits and forwarding
  always_comb begin
    nz_nxt      = nz_r;
    valid_nxt   = valid_r;
    fwd_vld_nxt = 1'b0;
    if (slot_b_r.vld && (slot_b_r.op == OP_CLEAR)) begin
      nz_nxt    = '0;
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[idx_b_r] = 1'b1;
      fwd_vld_nxt        = 1'b1;
      if ((cur_bin != '0) && (new_bin == '0)) begin
        nz_nxt = nz_r - NZ_W'(1);
      end else if ((cur_bin == '0) && (new_bin != '0)) begin
        nz_nxt = nz_r + NZ_W'(1);
      end
    end
  end

  assign done.vld     = slot_b_r.vld && slot_b_r.last;
  assign done.tag     = slot_b_r.tag;
  assign done.nz_zero = (nz_nxt == '0);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_b_r  <= '0;
      valid_r   <= '0;
      fwd_vld_r <= 1'b0;
      nz_r      <= '0;
    end else begin
      slot_b_r  <= slot_a;
      valid_r   <= valid_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      nz_r      <= nz_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_b_r <= idx_a;
    if (wr_en) begin
      fwd_idx_r  <= idx_b_r;
      fwd_data_r <= new_bin;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/anagram_window_search_core.sv =====
// Sliding-window anagram search core: window ring RAM, item front end,
// result queue. Depends on awsrch_pkg, awsrch_ram and awsrch_hist.
//
//  Channel  Dir  Payload                                    Accepted when
//  in_      in   tuser: command; tdata: symbol              in_tvalid & in_tready
//  out_     out  tdata: window_match, found, pattern_ovf    out_tvalid & out_tready
//
// A text item with a full window issues two slots: the leaving symbol is read from
// the ring RAM as the new symbol's bin is issued, then the pend register sends its
// bin through the single histogram read-modify-write port. Every other item issues
// one slot. Results go through the histogram stage register and the result queue.
// Up to 4 items may be outstanding; input stalls while a full-window text item sends
// its leaving-symbol slot and when the result queue could overflow.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module anagram_window_search_core
  import awsrch_pkg::*;
#(
  parameter int MAX_PATTERN = 256,
  parameter int ALPHABET    = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,    // [6:0] symbol
  input  wire logic [1:0] in_tuser,    // [1:0] command
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata    // [0] window_match, [1] found, [2] pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int IDX_W = $clog2(ALPHABET);

  // Symbol to bin table
  logic [IDX_W-1:0] bin_lut [NUM_SYMS];
  for (genvar g = 0; g < NUM_SYMS; g++) begin : g_lut
    assign bin_lut[g] = IDX_W'(g % ALPHABET);
  end

  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  item_tag_t        pend_tag_r, pend_tag_nxt;
  logic             found_r, found_nxt;
  logic [OUT_CNT_W-1:0] occ_r, occ_nxt;

  result_t              q_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] q_wr_r, q_rd_r;
  logic [OUT_CNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic             in_acc;
  logic             out_acc;
  cmd_t             cmd;
  logic [SYM_W-1:0] sym;
  slot_t            slot_a;
  logic [IDX_W-1:0] idx_a;
  done_t            done;
  result_t          res;

  logic             ring_we;
  logic             ring_re;
  logic [PTR_W-1:0] oldest;
  logic [SYM_W-1:0] ring_rd;
  logic [PTR_W-1:0] ptr_inc;
  logic [LEN_W-1:0] fill_mod;
  logic [LEN_W:0]   oldest_sum;
  logic [LEN_W-1:0] fill_inc;

  assign in_tready = !pend_r && (occ_r < OUT_CNT_W'(OUT_DEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign sym       = in_tdata[SYM_W-1:0];

  // Ring addressing: oldest slot is ptr minus fill, modulo ring size
  assign ptr_inc  = (ptr_r == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr_r + PTR_W'(1);
  assign fill_inc = fill_r + LEN_W'(1);
  assign fill_mod = (fill_r == LEN_W'(MAX_PATTERN)) ? '0 : fill_r;
  always_comb begin
    if ((LEN_W + 1)'(ptr_r) < (LEN_W + 1)'(fill_mod)) begin
      oldest_sum = (LEN_W + 1)'(ptr_r) + (LEN_W + 1)'(MAX_PATTERN) - (LEN_W + 1)'(fill_mod);
    end else begin
      oldest_sum = (LEN_W + 1)'(ptr_r) - (LEN_W + 1)'(fill_mod);
    end
  end
  assign oldest = oldest_sum[PTR_W-1:0];

  awsrch_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_PATTERN),
    .ADDR_W(PTR_W)
  ) u_ring_ram (
    .clk    (clk),
    .wr_en  (ring_we),
    .wr_addr(ptr_r),
    .wr_data(sym),
    .rd_en  (ring_re),
    .rd_addr(oldest),
    .rd_data(ring_rd)
  );

  // Front end: decode item, update lengths and pointer, issue slots
  always_comb begin
    plen_nxt     = plen_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = 1'b0;
    pend_tag_nxt = pend_tag_r;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    slot_a       = '0;
    idx_a        = bin_lut[sym];
    if (pend_r) begin
      // second slot of a full-window text item: take the leaving symbol out
      slot_a.vld  = 1'b1;
      slot_a.op   = OP_DEC;
      slot_a.last = 1'b1;
      slot_a.tag  = pend_tag_r;
      idx_a       = bin_lut[ring_rd];
    end else if (in_acc) begin
      slot_a.vld  = 1'b1;
      slot_a.last = 1'b1;
      case (cmd)
        CMD_CLEAR: begin
          plen_nxt            = '0;
          fill_nxt            = '0;
          ptr_nxt             = '0;
          slot_a.op           = OP_CLEAR;
          slot_a.tag.is_clear = 1'b1;
        end
        CMD_PATTERN: begin
          if (plen_r != LEN_W'(MAX_PATTERN)) begin
            plen_nxt  = plen_r + LEN_W'(1);
            slot_a.op = OP_DEC;
          end else begin
            slot_a.tag.ovf = 1'b1;
          end
        end
        CMD_TEXT: begin
          slot_a.tag.is_text = 1'b1;
          slot_a.tag.fill_eq = (fill_r == plen_r) || (fill_inc == plen_r);
          if (plen_r != '0) begin
            slot_a.op = OP_INC;
            ring_we   = 1'b1;
            ptr_nxt   = ptr_inc;
            if (fill_r == plen_r) begin
              ring_re      = 1'b1;
              pend_nxt     = 1'b1;
              slot_a.last  = 1'b0;
              pend_tag_nxt = slot_a.tag;
            end else begin
              fill_nxt = fill_inc;
            end
          end
        end
        default: begin
          // unused command: plain result, nothing changes
        end
      endcase
    end
  end

  awsrch_hist #(
    .ALPHABET(ALPHABET),
    .IDX_W   (IDX_W)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .slot_a(slot_a),
    .idx_a (idx_a),
    .done  (done)
  );

  // Result of a completed item
  always_comb begin
    res.match = done.tag.is_text && done.tag.fill_eq && done.nz_zero;
    res.ovf   = done.tag.ovf;
    found_nxt = found_r;
    if (done.vld) begin
      if (done.tag.is_clear) begin
        found_nxt = 1'b0;
      end else begin
        found_nxt = found_r || res.match;
      end
    end
    res.found = found_nxt;
  end

  // Outstanding items and result queue count
  always_comb begin
    occ_nxt   = occ_r + OUT_CNT_W'(in_acc) - OUT_CNT_W'(out_acc);
    q_cnt_nxt = q_cnt_r + OUT_CNT_W'(done.vld) - OUT_CNT_W'(out_acc);
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = {5'b0, q_mem_r[q_rd_r]};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      occ_r   <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      plen_r  <= plen_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
      occ_r   <= occ_nxt;
      q_cnt_r <= q_cnt_nxt;
      if (done.vld) begin
        q_wr_r <= q_wr_r + OUT_PTR_W'(1);
      end
      if (out_acc) begin
        q_rd_r <= q_rd_r + OUT_PTR_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_tag_r <= pend_tag_nxt;
    if (done.vld) begin
      q_mem_r[q_wr_r] <= res;
    end
  end

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("outstanding item count exceeds result queue depth");

  a_queue_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= occ_r)
    else $error("result queue holds more items than are outstanding");

  a_fill_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= plen_r)
    else $error("window fill exceeds pattern length");

  a_full_text_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_TEXT) && (plen_r != '0) && (fill_r == plen_r))
      |=> (pend_r && !in_tready))
    else $error("full-window text item did not schedule its leaving-symbol slot");

endmodule

`default_nettype wire

// ===== dv/anagram_window_search_core_tb.sv =====
// Self-checking testbench for anagram_window_search_core: a directed table, then random
// clear/pattern/text episodes, checked against typed-in results or an in-line model.
// Depends on awsrch_pkg and the core RTL.
`timescale 1ns / 1ps

module anagram_window_search_core_tb;
  import awsrch_pkg::*;

  localparam int         MAX_PAT      = 256;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         PHASE_ITEMS  = 30;
  localparam int         LONG_HOLD    = 200;

  // Result shorthands, fields {ovf, found, match}
  localparam result_t R_QUIET     = 3'b000;
  localparam result_t R_MATCH     = 3'b011;
  localparam result_t R_FOUND     = 3'b010;
  localparam result_t R_OVF       = 3'b100;

  // One directed row: command, symbol, repeat count, and a typed-in result if known
  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] sym;
    logic [8:0] reps;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam int NUM_ROWS = 23;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // empty pattern: text matches at once
    '{CMD_TEXT,    7'd0,   9'd1,   1'b1, R_MATCH},
    '{CMD_TEXT,    7'd127, 9'd1,   1'b1, R_MATCH},
    // unused command only shows the sticky flag
    '{CMD_UNUSED,  7'd127, 9'd1,   1'b1, R_FOUND},
    '{CMD_CLEAR,   7'd127, 9'd1,   1'b1, R_QUIET},
    '{CMD_UNUSED,  7'd0,   9'd1,   1'b1, R_QUIET},
    // pattern {0, 127, 0}
    '{CMD_PATTERN, 7'd0,   9'd1,   1'b1, R_QUIET},
    '{CMD_PATTERN, 7'd127, 9'd1,   1'b1, R_QUIET},
    '{CMD_PATTERN, 7'd0,   9'd1,   1'b1, R_QUIET},
    '{CMD_TEXT,    7'd127, 9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd0,   9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd0,   9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd127, 9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd5,   9'd1,   1'b0, R_QUIET},
    // pattern grows after text: window no longer full
    '{CMD_PATTERN, 7'd5,   9'd1,   1'b1, R_FOUND},
    '{CMD_TEXT,    7'd0,   9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd127, 9'd1,   1'b0, R_QUIET},
    '{CMD_TEXT,    7'd0,   9'd1,   1'b0, R_QUIET},
    '{CMD_CLEAR,   7'd0,   9'd1,   1'b1, R_QUIET},
    // fill the pattern to capacity, then one more is dropped
    '{CMD_PATTERN, 7'd85,  9'd256, 1'b1, R_QUIET},
    '{CMD_PATTERN, 7'd42,  9'd1,   1'b1, R_OVF},
    // a few text symbols into the full-length pattern, still dropped after
    '{CMD_TEXT,    7'd85,  9'd2,   1'b0, R_QUIET},
    '{CMD_PATTERN, 7'd0,   9'd1,   1'b1, R_OVF},
    '{CMD_CLEAR,   7'd127, 9'd1,   1'b1, R_QUIET}
  };

  // Idle and stall percentages per random phase
  localparam int TX_IDLE  [4] = '{0, 61, 0, 32};
  localparam int RX_STALL [4] = '{0, 0, 61, 32};

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [6:0] symbol
  logic [1:0] in_tuser;   // [1:0] command
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] window_match, [1] found, [2] pattern_overflow

  int          err_count;
  int          items_sent;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          rx_hold_cycles;
  result_t     expected_results [$];

  // Window model state
  logic signed [9:0] bin_diff [NUM_SYMS];
  logic [6:0]        win_ring [MAX_PAT];
  int unsigned       nz_count;
  int unsigned       pat_len;
  int unsigned       ring_wr;
  int unsigned       win_fill;
  bit                found_seen;

  anagram_window_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void clear_window_model();
    for (int i = 0; i < NUM_SYMS; i++) bin_diff[i] = '0;
    for (int i = 0; i < MAX_PAT; i++) win_ring[i] = '0;
    nz_count   = 0;
    pat_len    = 0;
    ring_wr    = 0;
    win_fill   = 0;
    found_seen = 1'b0;
  endfunction

  // Move one bin and keep the nonzero-bin count in step
  function automatic void adjust_bin(logic [6:0] s, logic signed [9:0] delta);
    logic signed [9:0] nv;
    nv = bin_diff[s] + delta;
    if (bin_diff[s] != 0 && nv == 0) nz_count--;
    else if (bin_diff[s] == 0 && nv != 0) nz_count++;
    bin_diff[s] = nv;
  endfunction

  // Apply one accepted item to the model and return its result
  function automatic result_t window_model_step(logic [1:0] cmd, logic [6:0] s);
    result_t     r;
    int unsigned oldest;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      clear_window_model();
    end else if (cmd == CMD_PATTERN) begin
      if (pat_len < MAX_PAT) begin
        adjust_bin(s, -10'sd1);
        pat_len++;
      end else begin
        r.ovf = 1'b1;
      end
    end else if (cmd == CMD_TEXT) begin
      if (pat_len > 0) begin
        if (win_fill >= pat_len) begin
          oldest = (ring_wr + MAX_PAT - (win_fill % MAX_PAT)) % MAX_PAT;
          adjust_bin(win_ring[oldest], -10'sd1);
        end else begin
          win_fill++;
        end
        win_ring[ring_wr] = s;
        ring_wr = (ring_wr + 1) % MAX_PAT;
        adjust_bin(s, 10'sd1);
      end
      if (win_fill == pat_len && nz_count == 0) begin
        r.match   = 1'b1;
        found_seen = 1'b1;
      end
    end
    r.found = found_seen;
    return r;
  endfunction

  // Offer one item after a random gap, record its expected result on acceptance
  task automatic send_item(input logic [1:0] cmd, input logic [6:0] s,
                           input bit typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, s};
    do @(posedge clk); while (!in_tready);
    predicted = window_model_step(cmd, s);
    expected_results.push_back(typed ? typed_res : predicted);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Sender stops until every outstanding result is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Text item, occasionally swapped for noise
  task automatic send_text_or_noise(input logic [6:0] s);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) send_item(CMD_UNUSED, 7'($urandom), 1'b0, R_QUIET);
    else if (roll < 6) send_item(CMD_PATTERN, s, 1'b0, R_QUIET);
    else if (roll < 9) send_item(CMD_TEXT, 7'($urandom), 1'b0, R_QUIET);
    else send_item(CMD_TEXT, s, 1'b0, R_QUIET);
  endtask

  // Clear (usually), load a short pattern over a narrow alphabet, then stream text
  // that mixes shuffled copies of the pattern with near-miss symbols
  task automatic send_episode();
    logic [6:0]  pat [$];
    logic [6:0]  perm [$];
    logic [6:0]  base;
    logic [6:0]  tmp;
    int unsigned span;
    int unsigned plen;
    int unsigned tlen;
    int unsigned sent_text;
    int unsigned pick;
    int unsigned j;
    if ($urandom_range(99) < 85) send_item(CMD_CLEAR, 7'($urandom), 1'b0, R_QUIET);
    pick = $urandom_range(99);
    if (pick < 5) plen = 0;
    else if (pick < 10) plen = $urandom_range(40, 20);
    else plen = $urandom_range(6, 1);
    base = 7'($urandom);
    span = $urandom_range(4, 1);
    for (int k = 0; k < plen; k++) begin
      pat.push_back(base + 7'($urandom_range(span - 1)));
      send_item(CMD_PATTERN, pat[k], 1'b0, R_QUIET);
    end
    tlen = $urandom_range(3 * plen + 4, plen + 1);
    sent_text = 0;
    while (sent_text < tlen) begin
      if (plen > 0 && $urandom_range(1) == 0) begin
        perm = pat;
        for (int k = plen - 1; k > 0; k--) begin
          j = $urandom_range(k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        for (int k = 0; k < plen; k++) send_text_or_noise(perm[k]);
        sent_text += plen;
      end else begin
        send_text_or_noise(base + 7'($urandom_range(span - 1)));
        sent_text++;
      end
    end
  endtask

  // Result receiver: random stalls, plus a long hold when requested
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: tdata %h", out_tdata);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.match) begin
          $error("window_match: expected %0b, got %0b", want.match, out_tdata[0]);
          err_count++;
        end
        if (out_tdata[1] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tdata[1]);
          err_count++;
        end
        if (out_tdata[2] !== want.ovf) begin
          $error("pattern_overflow: expected %0b, got %0b", want.ovf, out_tdata[2]);
          err_count++;
        end
        if (out_tdata[7:3] !== 5'd0) begin
          $error("tdata padding: expected 0, got %h", out_tdata[7:3]);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_CLEAR;
    rst_n          = 1'b0;
    err_count      = 0;
    items_sent     = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cycles = 0;
    clear_window_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int n = 0; n < DIRECTED[r].reps; n++) begin
        send_item(DIRECTED[r].cmd, DIRECTED[r].sym, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end
    wait_for_results();

    // Random phases; the first one opens with a long receiver hold
    for (int p = 0; p < 4; p++) begin
      int phase_end;
      tx_idle_pct  = TX_IDLE[p];
      rx_stall_pct = RX_STALL[p];
      if (p == 0) rx_hold_cycles = LONG_HOLD;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_episode();
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
